### src/tt_pkg.sv
// Shared types, character codes and defaults for the text terminal cursor and escape engine.
package tt_pkg;

    // Register indexes of the configuration port
    localparam logic [1:0] REG_COLUMNS     = 2'd0;
    localparam logic [1:0] REG_ROWS        = 2'd1;
    localparam logic [1:0] REG_GLYPH_COUNT = 2'd2;

    localparam logic [7:0] COLUMNS_RESET     = 8'd80;
    localparam logic [7:0] ROWS_RESET        = 8'd25;
    localparam logic [8:0] GLYPH_COUNT_RESET = 9'd256;

    localparam int TAB_WIDTH_DEFAULT   = 8;
    localparam int QUEUE_DEPTH_DEFAULT = 2;

    // Character codes
    localparam logic [7:0] CH_ESC      = 8'h1b;
    localparam logic [7:0] CH_TAB      = 8'h09;
    localparam logic [7:0] CH_NEWLINE  = 8'h0a;
    localparam logic [7:0] CH_SGR_END  = 8'h6d;
    localparam logic [7:0] CH_SEMI     = 8'h3b;
    localparam logic [7:0] CH_LBRACKET = 8'h5b;
    localparam logic [7:0] CH_ZERO     = 8'h30;

    // Color selection codes
    localparam logic [31:0] SGR_RESET     = 32'd0;
    localparam logic [31:0] SGR_FG_FIRST  = 32'd30;
    localparam logic [31:0] SGR_FG_LAST   = 32'd37;
    localparam logic [2:0]  COLOR_DEFAULT = 3'd7;

    // Result action codes
    localparam logic ACT_DRAW   = 1'b0;
    localparam logic ACT_SCROLL = 1'b1;

    typedef enum logic [1:0] {
        OP_DRAW,
        OP_TAB,
        OP_NEWLINE
    } tt_op_t;

    typedef struct packed {
        tt_op_t     op;
        logic [7:0] glyph;
        logic [2:0] color;
    } tt_cmd_t;

    typedef struct packed {
        logic    valid;
        tt_cmd_t cmd;
    } tt_push_t;

    typedef enum logic {
        BK_RUN,
        BK_SCROLL
    } tt_back_state_t;

endpackage

### src/tt_front.sv
// Front end: accepts character bytes, runs the escape parser and queues cursor commands.
module tt_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic [7:0]       char_in,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [8:0]       glyph_count,
    input  logic             q_ready,
    output tt_pkg::tt_push_t push
);

    logic        in_escape_reg;
    logic        in_escape_next;
    logic [31:0] esc_num_reg;
    logic [31:0] esc_num_next;
    logic [2:0]  color_reg;
    logic [2:0]  color_next;
    logic [2:0]  applied_color;
    logic        accept;

    assign in_ready = q_ready;
    assign accept   = in_valid && q_ready;

    always_comb
    begin
        applied_color = color_reg;
        if (esc_num_reg == tt_pkg::SGR_RESET)
        begin
            applied_color = tt_pkg::COLOR_DEFAULT;
        end
        else if (esc_num_reg >= tt_pkg::SGR_FG_FIRST && esc_num_reg <= tt_pkg::SGR_FG_LAST)
        begin
            applied_color = 3'(esc_num_reg - tt_pkg::SGR_FG_FIRST);
        end
    end

    always_comb
    begin
        in_escape_next  = in_escape_reg;
        esc_num_next    = esc_num_reg;
        color_next      = color_reg;
        push.valid      = 1'b0;
        push.cmd.op     = tt_pkg::OP_DRAW;
        push.cmd.glyph  = char_in;
        push.cmd.color  = color_reg;
        if (accept)
        begin
            if (in_escape_reg)
            begin
                case (char_in)
                    tt_pkg::CH_SGR_END:
                    begin
                        in_escape_next = 1'b0;
                        color_next     = applied_color;
                        esc_num_next   = '0;
                    end
                    tt_pkg::CH_SEMI:
                    begin
                        color_next   = applied_color;
                        esc_num_next = '0;
                    end
                    tt_pkg::CH_LBRACKET:
                    begin
                        esc_num_next = '0;
                    end
                    default:
                    begin
                        // Decimal fold with plain 32-bit wrap: n * 10 + (byte - '0').
                        esc_num_next = (esc_num_reg << 3) + (esc_num_reg << 1)
                                       + {24'b0, char_in} - {24'b0, tt_pkg::CH_ZERO};
                    end
                endcase
            end
            else
            begin
                case (char_in)
                    tt_pkg::CH_ESC:
                    begin
                        in_escape_next = 1'b1;
                    end
                    tt_pkg::CH_TAB:
                    begin
                        push.valid  = 1'b1;
                        push.cmd.op = tt_pkg::OP_TAB;
                    end
                    tt_pkg::CH_NEWLINE:
                    begin
                        push.valid  = 1'b1;
                        push.cmd.op = tt_pkg::OP_NEWLINE;
                    end
                    default:
                    begin
                        push.valid = ({1'b0, char_in} < glyph_count);
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_escape_reg <= 1'b0;
            esc_num_reg   <= '0;
            color_reg     <= tt_pkg::COLOR_DEFAULT;
        end
        else
        begin
            in_escape_reg <= in_escape_next;
            esc_num_reg   <= esc_num_next;
            color_reg     <= color_next;
        end
    end

endmodule

### src/tt_queue.sv
// Short command queue between the front end and the cursor back end.
module tt_queue #(
    parameter int DEPTH = tt_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic             clk,
    input  logic             rst_n,
    input  tt_pkg::tt_push_t push,
    output logic             q_ready,
    output tt_pkg::tt_push_t head,
    input  logic             pop
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    tt_pkg::tt_cmd_t mem_reg [DEPTH];
    logic [AW-1:0]   wr_ptr_reg;
    logic [AW-1:0]   wr_ptr_next;
    logic [AW-1:0]   rd_ptr_reg;
    logic [AW-1:0]   rd_ptr_next;
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   count_next;
    logic            do_push;
    logic            do_pop;

    assign q_ready   = (count_reg != CW'(DEPTH));
    assign head.valid = (count_reg != '0);
    assign head.cmd   = mem_reg[rd_ptr_reg];
    assign do_push   = push.valid && q_ready;
    assign do_pop    = pop && head.valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push.cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

### src/tt_back.sv
// Back end: moves the cursor for each queued command and drives the result register.
module tt_back #(
    parameter int TAB_WIDTH = tt_pkg::TAB_WIDTH_DEFAULT
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic [7:0]       columns,
    input  logic [7:0]       rows,
    input  tt_pkg::tt_push_t head,
    output logic             pop,
    output logic             action,
    output logic [7:0]       glyph_code,
    output logic [7:0]       cell_column,
    output logic [7:0]       cell_row,
    output logic [2:0]       color_index,
    output logic             last,
    output logic             out_valid,
    input  logic             out_ready
);

    localparam int PW = (TAB_WIDTH > 1) ? $clog2(TAB_WIDTH) : 1;

    tt_pkg::tt_back_state_t state_reg;
    tt_pkg::tt_back_state_t state_next;
    logic [7:0]    col_reg;
    logic [7:0]    col_next;
    logic [7:0]    row_reg;
    logic [7:0]    row_next;
    // Column modulo the tab width, tracked alongside the column.
    logic [PW-1:0] phase_reg;
    logic [PW-1:0] phase_next;
    logic          out_valid_reg;
    logic          out_valid_next;
    logic          action_reg;
    logic          action_next;
    logic [7:0]    glyph_reg;
    logic [7:0]    glyph_next;
    logic [7:0]    ccol_reg;
    logic [7:0]    ccol_next;
    logic [7:0]    crow_reg;
    logic [7:0]    crow_next;
    logic [2:0]    color_reg;
    logic [2:0]    color_next;
    logic          last_reg;
    logic          last_next;

    logic          load_ok;
    logic          wrap;
    logic          scroll;
    logic [8:0]    col_plus;
    logic [8:0]    tab_stop;
    logic [8:0]    row_plus;

    assign load_ok  = !out_valid_reg || out_ready;
    assign col_plus = {1'b0, col_reg} + 9'd1;
    assign tab_stop = {1'b0, col_reg} + (9'(TAB_WIDTH) - 9'(phase_reg));
    assign row_plus = {1'b0, row_reg} + 9'd1;

    always_comb
    begin
        state_next     = state_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        phase_next     = phase_reg;
        pop            = 1'b0;
        wrap           = 1'b0;
        scroll         = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;
        action_next    = action_reg;
        glyph_next     = glyph_reg;
        ccol_next      = ccol_reg;
        crow_next      = crow_reg;
        color_next     = color_reg;
        last_next      = last_reg;
        case (state_reg)
            tt_pkg::BK_SCROLL:
            begin
                if (load_ok)
                begin
                    out_valid_next = 1'b1;
                    action_next    = tt_pkg::ACT_SCROLL;
                    glyph_next     = '0;
                    ccol_next      = '0;
                    crow_next      = '0;
                    color_next     = '0;
                    last_next      = 1'b1;
                    state_next     = tt_pkg::BK_RUN;
                end
            end
            tt_pkg::BK_RUN:
            begin
                if (load_ok && head.valid)
                begin
                    pop = 1'b1;
                    case (head.cmd.op)
                        tt_pkg::OP_DRAW:
                        begin
                            wrap = (col_plus >= {1'b0, columns});
                            if (!wrap)
                            begin
                                col_next   = col_plus[7:0];
                                phase_next = (phase_reg == PW'(TAB_WIDTH - 1)) ?
                                             '0 : phase_reg + 1'b1;
                            end
                        end
                        tt_pkg::OP_TAB:
                        begin
                            wrap = (tab_stop >= {1'b0, columns});
                            if (!wrap)
                            begin
                                col_next   = tab_stop[7:0];
                                phase_next = '0;
                            end
                        end
                        default:
                        begin
                            wrap = 1'b1;
                        end
                    endcase
                    if (wrap)
                    begin
                        col_next   = '0;
                        phase_next = '0;
                        scroll     = (row_plus >= {1'b0, rows});
                        if (scroll)
                        begin
                            row_next = (rows == '0) ? '0 : rows - 8'd1;
                        end
                        else
                        begin
                            row_next = row_plus[7:0];
                        end
                    end
                    if (head.cmd.op == tt_pkg::OP_DRAW)
                    begin
                        out_valid_next = 1'b1;
                        action_next    = tt_pkg::ACT_DRAW;
                        glyph_next     = head.cmd.glyph;
                        ccol_next      = col_reg;
                        crow_next      = row_reg;
                        color_next     = head.cmd.color;
                        last_next      = !scroll;
                        if (scroll)
                        begin
                            state_next = tt_pkg::BK_SCROLL;
                        end
                    end
                    else if (scroll)
                    begin
                        out_valid_next = 1'b1;
                        action_next    = tt_pkg::ACT_SCROLL;
                        glyph_next     = '0;
                        ccol_next      = '0;
                        crow_next      = '0;
                        color_next     = '0;
                        last_next      = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = tt_pkg::BK_RUN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tt_pkg::BK_RUN;
            col_reg       <= '0;
            row_reg       <= '0;
            phase_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        action_reg <= action_next;
        glyph_reg  <= glyph_next;
        ccol_reg   <= ccol_next;
        crow_reg   <= crow_next;
        color_reg  <= color_next;
        last_reg   <= last_next;
    end

    assign out_valid   = out_valid_reg;
    assign action      = action_reg;
    assign glyph_code  = glyph_reg;
    assign cell_column = ccol_reg;
    assign cell_row    = crow_reg;
    assign color_index = color_reg;
    assign last        = last_reg;

    // A pending scroll always sits behind a draw that is still on the output.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == tt_pkg::BK_SCROLL |-> out_valid_reg)
        else $error("pending scroll without a draw on the output");

    // A draw that is not the final result must be followed by the pending scroll.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && action_reg == tt_pkg::ACT_DRAW && !last_reg
        |-> state_reg == tt_pkg::BK_SCROLL)
        else $error("draw marked not last with no scroll pending");

    // A scroll is always the final result of its request and carries a blank cell.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && action_reg == tt_pkg::ACT_SCROLL
        |-> last_reg && glyph_reg == '0 && ccol_reg == '0 && crow_reg == '0
            && color_reg == '0)
        else $error("malformed scroll result");

    // The queue is never drained while a scroll is still owed.
    assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> state_reg == tt_pkg::BK_RUN && load_ok)
        else $error("command taken while output busy or scroll pending");

endmodule

### src/text_terminal_cursor_and_escape.sv
// Top level of the text terminal cursor and escape engine: configuration registers and wiring.
//
//  Channel  Signals                                         Direction
//  input    in_valid, in_ready, char_in                     request in
//  output   out_valid, out_ready, action, glyph_code,       request out
//           cell_column, cell_row, color_index, last
//  config   cfg_valid, cfg_ready, cfg_index, cfg_data       write in
//
//  The front end takes one request per cycle while the command queue has room; escape
//  bytes finish in the front end in that cycle. The back end issues at most one result per
//  cycle through its single output register: a draw gives a draw result, a tab or newline
//  a scroll result only when it scrolls, and a scrolling draw a draw and then a scroll. Reset
//  returns the cursor to the top left, clears the escape parser and selects white. A stalled
//  output holds the back end; the queue keeps the front end accepting until it fills.
module text_terminal_cursor_and_escape #(
    parameter int TAB_WIDTH   = tt_pkg::TAB_WIDTH_DEFAULT,
    parameter int QUEUE_DEPTH = tt_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic [7:0] char_in,
    input  logic       in_valid,
    output logic       in_ready,
    output logic       action,
    output logic [7:0] glyph_code,
    output logic [7:0] cell_column,
    output logic [7:0] cell_row,
    output logic [2:0] color_index,
    output logic       last,
    output logic       out_valid,
    input  logic       out_ready,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [8:0] cfg_data
);

    logic [7:0] columns_reg;
    logic [7:0] columns_next;
    logic [7:0] rows_reg;
    logic [7:0] rows_next;
    logic [8:0] glyph_count_reg;
    logic [8:0] glyph_count_next;

    tt_pkg::tt_push_t push;
    tt_pkg::tt_push_t head;
    logic             q_ready;
    logic             pop;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        columns_next     = columns_reg;
        rows_next        = rows_reg;
        glyph_count_next = glyph_count_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                tt_pkg::REG_COLUMNS:     columns_next     = cfg_data[7:0];
                tt_pkg::REG_ROWS:        rows_next        = cfg_data[7:0];
                tt_pkg::REG_GLYPH_COUNT: glyph_count_next = cfg_data;
                default:                 ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            columns_reg     <= tt_pkg::COLUMNS_RESET;
            rows_reg        <= tt_pkg::ROWS_RESET;
            glyph_count_reg <= tt_pkg::GLYPH_COUNT_RESET;
        end
        else
        begin
            columns_reg     <= columns_next;
            rows_reg        <= rows_next;
            glyph_count_reg <= glyph_count_next;
        end
    end

    tt_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .char_in     (char_in),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .glyph_count (glyph_count_reg),
        .q_ready     (q_ready),
        .push        (push)
    );

    tt_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .q_ready (q_ready),
        .head    (head),
        .pop     (pop)
    );

    tt_back #(
        .TAB_WIDTH (TAB_WIDTH)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .columns     (columns_reg),
        .rows        (rows_reg),
        .head        (head),
        .pop         (pop),
        .action      (action),
        .glyph_code  (glyph_code),
        .cell_column (cell_column),
        .cell_row    (cell_row),
        .color_index (color_index),
        .last        (last),
        .out_valid   (out_valid),
        .out_ready   (out_ready)
    );

endmodule
